[rtl/fmosc_pkg.sv]
// Shared constants, microcode types and table helpers for the two-operator FM oscillator.
// Self-contained; imported by fm_two_operator_feedback_osc_core and the testbench.
package fmosc_pkg;

    // Default sizes
    localparam int DEF_TABLE_SIZE          = 256;
    localparam int DEF_SAMPLE_BITS         = 16;
    localparam int DEF_PHASE_FRACTION_BITS = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_INC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULATOR_INC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_OFS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_FB    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODULATOR_FB  = 3'd4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_DATA_W-1:0] INDEX_OFS_RESET = 32'd2670177;

    // Quarter wave angle pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    // Taylor denominators (2k)(2k+1) for k = 1..10
    localparam logic [63:0] TAYLOR_DIV [10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    // Feedback dead zone: 0.005 rad per table size, in 16.16 table units
    localparam logic [63:0] FB_SCALE = 64'd5215188;
    localparam logic [63:0] FB_DENOM = 64'd100000;

    // Microcode step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] ST_MOD_FB  = 4'd1;
    localparam logic [STEP_W-1:0] ST_MOD_SUM = 4'd2;
    localparam logic [STEP_W-1:0] ST_MOD_RD  = 4'd3;
    localparam logic [STEP_W-1:0] ST_MOD_MUL = 4'd4;
    localparam logic [STEP_W-1:0] ST_MOD_WB  = 4'd5;
    localparam logic [STEP_W-1:0] ST_CAR_FB  = 4'd6;
    localparam logic [STEP_W-1:0] ST_CAR_IDX = 4'd7;
    localparam logic [STEP_W-1:0] ST_CAR_SUM = 4'd8;
    localparam logic [STEP_W-1:0] ST_CAR_RD  = 4'd9;
    localparam logic [STEP_W-1:0] ST_CAR_MUL = 4'd10;
    localparam logic [STEP_W-1:0] ST_CAR_WB  = 4'd11;

    // Sequencing conditions
    localparam logic [1:0] C_NEXT     = 2'd0;
    localparam logic [1:0] C_WAIT_REQ = 2'd1;
    localparam logic [1:0] C_DONE     = 2'd2;

    // Multiplier operand selects
    localparam logic [2:0] MUL_NONE   = 3'd0;
    localparam logic [2:0] MUL_MOD_FB = 3'd1;
    localparam logic [2:0] MUL_CAR_FB = 3'd2;
    localparam logic [2:0] MUL_INDEX  = 3'd3;
    localparam logic [2:0] MUL_INTERP = 3'd4;

    // Phase accumulator operations
    localparam logic [1:0] ACC_HOLD     = 2'd0;
    localparam logic [1:0] ACC_LOAD_MOD = 2'd1;
    localparam logic [1:0] ACC_LOAD_CAR = 2'd2;
    localparam logic [1:0] ACC_ADD      = 2'd3;

    typedef struct packed {
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
        logic [2:0]        mul_sel;
        logic [1:0]        acc_op;
        logic              rom_rd;
        logic              wb_mod;
        logic              wb_car;
        logic              out_ld;
    } ucode_t;

    // Control store: one word per step
    function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        w.cond   = C_NEXT;
        w.target = ST_IDLE;
        case (step)
            ST_IDLE:    w.cond = C_WAIT_REQ;
            ST_MOD_FB:
            begin
                w.mul_sel = MUL_MOD_FB;
                w.acc_op  = ACC_LOAD_MOD;
            end
            ST_MOD_SUM: w.acc_op = ACC_ADD;
            ST_MOD_RD:  w.rom_rd = 1'b1;
            ST_MOD_MUL: w.mul_sel = MUL_INTERP;
            ST_MOD_WB:
            begin
                w.wb_mod = 1'b1;
                w.acc_op = ACC_LOAD_CAR;
            end
            ST_CAR_FB:  w.mul_sel = MUL_CAR_FB;
            ST_CAR_IDX:
            begin
                w.acc_op  = ACC_ADD;
                w.mul_sel = MUL_INDEX;
            end
            ST_CAR_SUM: w.acc_op = ACC_ADD;
            ST_CAR_RD:  w.rom_rd = 1'b1;
            ST_CAR_MUL: w.mul_sel = MUL_INTERP;
            ST_CAR_WB:
            begin
                w.wb_car = 1'b1;
                w.out_ld = 1'b1;
                w.cond   = C_DONE;
            end
            default:    w.cond = C_DONE;
        endcase
        return w;
    endfunction

    // Q30 Taylor sine over a quarter wave, scaled to amp and rounded
    function automatic logic [63:0] quarter_sine(input logic [63:0] x, input logic [63:0] amp);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] s;
        int          k;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (k = 1; k <= 10; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        s = (sum * amp + (64'd1 << 29)) >> 30;
        if (s > amp)
            s = amp;
        return s;
    endfunction

endpackage

[rtl/fm_two_operator_feedback_osc_core.sv]
// Two-operator FM oscillator with self feedback: microcoded sequencer over one shared multiplier.
// Depends on fmosc_pkg for microcode, register indexes and the sine table builder.
//
//  channel   signals                                   direction  beat
//  request   in_valid, in_ready, sample_request        in         one sample request
//  result    out_valid, out_ready, carrier_sample,      out        one sample pair
//            modulator_sample
//  config    cfg_we, cfg_index, cfg_data               in         one register write
//
// A request with sample_request high runs through twelve microcode steps from acceptance to
// the result register, five of them on the single shared multiplier, the rest on the phase
// adder and the sine table read. The next request is taken the cycle after the result is
// loaded, so only one request is in flight at a time.
// A stalled result holds the sequencer on its last step until the result register frees.
// Reset clears phases, last samples and configuration registers to their defaults; the sine table is constant.
module fm_two_operator_feedback_osc_core
    import fmosc_pkg::*;
#(
    parameter int TABLE_SIZE          = DEF_TABLE_SIZE,
    parameter int SAMPLE_BITS         = DEF_SAMPLE_BITS,
    parameter int PHASE_FRACTION_BITS = DEF_PHASE_FRACTION_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          sample_request,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] carrier_sample,
    output logic signed [SAMPLE_BITS-1:0] modulator_sample,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int LOG_TS   = $clog2(TABLE_SIZE);
    localparam int QUARTER  = TABLE_SIZE / 4;
    localparam int HALF     = TABLE_SIZE / 2;
    localparam int ROM_AW   = LOG_TS + 1;
    localparam int PH_W     = LOG_TS + PHASE_FRACTION_BITS;
    localparam int TOT_FRAC = 16 + SAMPLE_BITS - 1;
    localparam int TOT_W    = TOT_FRAC + LOG_TS;
    localparam int ALIGN_UP = (TOT_FRAC >= PHASE_FRACTION_BITS) ?
                              (TOT_FRAC - PHASE_FRACTION_BITS) : 0;
    localparam int ALIGN_DN = (PHASE_FRACTION_BITS > TOT_FRAC) ?
                              (PHASE_FRACTION_BITS - TOT_FRAC) : 0;
    localparam int AW       = 33;
    localparam int BW       = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
    localparam int PW       = AW + BW;
    localparam logic [63:0] AMP      = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam logic [63:0] FB_LIMIT = (64'(TABLE_SIZE) * FB_SCALE) / FB_DENOM;
    localparam logic [PW-1:0] ROUND_HALF = PW'(64'd1 << 15);

    // Constant sine table, built from a mirrored quarter wave
    logic signed [SAMPLE_BITS-1:0] sine_rom [TABLE_SIZE+1];

    for (genvar gi = 0; gi <= TABLE_SIZE; gi++)
    begin : g_rom
        localparam int J = (gi > HALF) ? (gi - HALF) : gi;
        localparam int K = (J > QUARTER) ? (HALF - J) : J;
        localparam logic [63:0] X   = (HALF_PI_Q30 * 64'(K)) / QUARTER;
        localparam logic [63:0] MAG = quarter_sine(X, AMP);
        localparam logic signed [SAMPLE_BITS-1:0] MAGS = MAG[SAMPLE_BITS-1:0];
        assign sine_rom[gi] = (gi > HALF) ? -MAGS : MAGS;
    end

    // Configuration registers
    logic [31:0]        carrier_inc_reg;
    logic [31:0]        modulator_inc_reg;
    logic signed [31:0] index_ofs_reg;
    logic signed [31:0] carrier_fb_reg;
    logic signed [31:0] modulator_fb_reg;

    // Sequencer and datapath state
    logic [STEP_W-1:0]             step_reg, step_next;
    ucode_t                        uw;
    logic [PH_W-1:0]               car_phase_reg, mod_phase_reg;
    logic signed [SAMPLE_BITS-1:0] last_car_reg, last_mod_reg;
    logic                          fb_on_reg, fb_on_next;
    logic [TOT_W-1:0]              acc_reg, acc_next;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg;
    logic [15:0]                   f_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] carrier_sample_reg, modulator_sample_reg;

    logic                          go;
    logic                          busy;
    logic [32:0]                   abs_car_fb, abs_mod_fb;
    logic signed [AW-1:0]          mul_a;
    logic signed [BW-1:0]          mul_b;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PW-1:0]          interp_sum;
    logic signed [SAMPLE_BITS-1:0] interp_val;
    logic [LOG_TS-1:0]             tab_idx;
    logic [ROM_AW-1:0]             addr_a, addr_b;

    assign uw        = ucode_word(step_reg);
    assign in_ready  = (step_reg == ST_IDLE);
    assign go        = in_valid && in_ready && sample_request;
    assign busy      = out_valid_reg && !out_ready;

    assign out_valid        = out_valid_reg;
    assign carrier_sample   = carrier_sample_reg;
    assign modulator_sample = modulator_sample_reg;

    // Feedback dead zone check on the current settings
    assign abs_car_fb = carrier_fb_reg[31] ? (33'd0 - {1'b1, carrier_fb_reg})
                                           : {1'b0, carrier_fb_reg};
    assign abs_mod_fb = modulator_fb_reg[31] ? (33'd0 - {1'b1, modulator_fb_reg})
                                             : {1'b0, modulator_fb_reg};
    assign fb_on_next = (64'(abs_car_fb) > FB_LIMIT) || (64'(abs_mod_fb) > FB_LIMIT);

    // Step sequencing
    always_comb
    begin
        case (uw.cond)
            C_NEXT:     step_next = step_reg + STEP_W'(1);
            C_WAIT_REQ: step_next = go ? (step_reg + STEP_W'(1)) : uw.target;
            C_DONE:     step_next = busy ? step_reg : uw.target;
            default:    step_next = ST_IDLE;
        endcase
    end

    // Shared multiplier operand select
    assign diff = {b_reg[SAMPLE_BITS-1], b_reg} - {a_reg[SAMPLE_BITS-1], a_reg};

    always_comb
    begin
        case (uw.mul_sel)
            MUL_MOD_FB:
            begin
                mul_a = fb_on_reg ? AW'(modulator_fb_reg) : '0;
                mul_b = BW'(last_mod_reg);
            end
            MUL_CAR_FB:
            begin
                mul_a = fb_on_reg ? AW'(carrier_fb_reg) : '0;
                mul_b = BW'(last_car_reg);
            end
            MUL_INDEX:
            begin
                mul_a = AW'(index_ofs_reg);
                mul_b = BW'(last_mod_reg);
            end
            MUL_INTERP:
            begin
                mul_a = AW'(diff);
                mul_b = BW'({1'b0, f_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Total phase accumulator
    always_comb
    begin
        case (uw.acc_op)
            ACC_LOAD_MOD: acc_next = TOT_W'({{TOT_W{1'b0}}, mod_phase_reg} >> ALIGN_DN) << ALIGN_UP;
            ACC_LOAD_CAR: acc_next = TOT_W'({{TOT_W{1'b0}}, car_phase_reg} >> ALIGN_DN) << ALIGN_UP;
            ACC_ADD:      acc_next = acc_reg + TOT_W'(prod_reg);
            default:      acc_next = acc_reg;
        endcase
    end

    // Table addresses: floor index and its right neighbor
    assign tab_idx = acc_reg[TOT_W-1:TOT_FRAC];
    assign addr_a  = {1'b0, tab_idx};
    assign addr_b  = {1'b0, tab_idx} + ROM_AW'(1);

    // Linear interpolation with round half up
    assign interp_sum = (PW'(a_reg) <<< 16) + prod_reg + ROUND_HALF;
    assign interp_val = interp_sum[SAMPLE_BITS+15:16];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_inc_reg   <= '0;
            modulator_inc_reg <= '0;
            index_ofs_reg     <= INDEX_OFS_RESET;
            carrier_fb_reg    <= '0;
            modulator_fb_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CARRIER_INC:   carrier_inc_reg   <= cfg_data;
                REG_MODULATOR_INC: modulator_inc_reg <= cfg_data;
                REG_INDEX_OFS:     index_ofs_reg     <= cfg_data;
                REG_CARRIER_FB:    carrier_fb_reg    <= cfg_data;
                REG_MODULATOR_FB:  modulator_fb_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Control and oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            car_phase_reg <= '0;
            mod_phase_reg <= '0;
            last_car_reg  <= '0;
            last_mod_reg  <= '0;
            fb_on_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            // Advance both phase accumulators on an accepted request
            if (go)
            begin
                car_phase_reg <= car_phase_reg + PH_W'(carrier_inc_reg);
                mod_phase_reg <= mod_phase_reg + PH_W'(modulator_inc_reg);
                fb_on_reg     <= fb_on_next;
            end
            if (uw.wb_mod)
                last_mod_reg <= interp_val;
            if (uw.wb_car)
                last_car_reg <= interp_val;
            // Hold the result beat until taken
            if (uw.out_ld && !busy)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (uw.mul_sel != MUL_NONE)
            prod_reg <= prod_next;
        if (uw.rom_rd)
        begin
            a_reg <= sine_rom[addr_a];
            b_reg <= sine_rom[addr_b];
            f_reg <= acc_reg[TOT_FRAC-1:TOT_FRAC-16];
        end
        if (uw.out_ld && !busy)
        begin
            carrier_sample_reg   <= interp_val;
            modulator_sample_reg <= last_mod_reg;
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for fm_two_operator_feedback_osc_core: predicts each FM sample pair.
// Depends on fmosc_pkg (register indexes, sizes) and the core RTL; no other files.
module testbench;
    import fmosc_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int TBL            = DEF_TABLE_SIZE;
    localparam int SBITS          = DEF_SAMPLE_BITS;
    localparam int PFRAC          = DEF_PHASE_FRACTION_BITS;
    localparam int TOT_FRAC       = 16 + SBITS - 1;
    localparam int PHASE_SHIFT    = TOT_FRAC - PFRAC;
    localparam int AMP            = (1 << (SBITS - 1)) - 1;
    // 0.005 rad scaled to the table, in 16.16 table units
    localparam int FB_DEAD_ZONE   = (TBL * 5215188) / 100000;
    localparam logic [63:0] RIGHT_ANGLE_Q30 = 64'd1686629713;
    localparam logic [31:0] ONE_RADIAN      = 32'd2670177;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int CALM_TAIL       = 200;
    localparam int SETTLE_CYCLES   = 24;
    localparam int MAX_REPORTS     = 100;
    localparam int TIMEOUT_CYCLES  = 600000;

    typedef struct packed {
        logic signed [SBITS-1:0] carrier;
        logic signed [SBITS-1:0] modulator;
    } osc_sample_t;

    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    in_valid       = 1'b0;
    logic                    in_ready;
    logic                    sample_request = 1'b0;
    logic                    out_valid;
    logic                    out_ready      = 1'b0;
    logic signed [SBITS-1:0] carrier_sample;
    logic signed [SBITS-1:0] modulator_sample;
    logic                    cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index      = '0;
    logic [CFG_DATA_W-1:0]   cfg_data       = '0;

    // Oscillator state and register copies
    logic [31:0]             car_inc_reg = 32'd0;
    logic [31:0]             mod_inc_reg = 32'd0;
    logic [31:0]             index_reg   = ONE_RADIAN;
    logic [31:0]             car_fb_reg  = 32'd0;
    logic [31:0]             mod_fb_reg  = 32'd0;
    logic [31:0]             car_phase   = 32'd0;
    logic [31:0]             mod_phase   = 32'd0;
    logic signed [SBITS-1:0] last_car    = '0;
    logic signed [SBITS-1:0] last_mod    = '0;
    int                      sine_tbl [0:TBL];

    logic                    pending_requests [$];
    osc_sample_t             expected_samples [$];
    logic                    in_taken     = 1'b0;
    int                      in_gap       = 0;
    int                      out_gap      = 0;
    int                      in_idle_pct  = 0;
    int                      out_idle_pct = 0;
    int                      error_count  = 0;

    fm_two_operator_feedback_osc_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_request   (sample_request),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .carrier_sample   (carrier_sample),
        .modulator_sample (modulator_sample),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Build the sine table: Q30 Taylor series over a quarter wave, then mirror
    initial
    begin : build_sine
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] s;
        int          i;
        int          k;
        int          q;
        q = TBL / 4;
        for (i = 0; i <= q; i++)
        begin
            x    = (RIGHT_ANGLE_Q30 * 64'(i)) / 64'(q);
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (k = 1; k <= 10; k++)
            begin
                term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
                if (k % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            s = (acc * 64'(AMP) + (64'd1 << 29)) >> 30;
            sine_tbl[i] = (s > 64'(AMP)) ? AMP : int'(s);
        end
        for (i = q + 1; i <= 2 * q; i++)
            sine_tbl[i] = sine_tbl[2 * q - i];
        for (i = 2 * q + 1; i <= TBL; i++)
            sine_tbl[i] = -sine_tbl[i - 2 * q];
    end

    // Interpolated table read at a total phase with TOT_FRAC fraction bits
    function automatic logic signed [SBITS-1:0] sine_lookup(input logic [63:0] total);
        int unsigned slot;
        longint      frac;
        longint      lo;
        longint      hi;
        longint      mix;
        slot = (total >> TOT_FRAC) % TBL;
        frac = longint'((total >> (TOT_FRAC - 16)) & 64'hFFFF);
        lo   = sine_tbl[slot];
        hi   = sine_tbl[slot + 1];
        mix  = lo * 65536 + (hi - lo) * frac + 32768;
        return SBITS'(mix >>> 16);
    endfunction

    // Advance both operators by one sample and return the new pair
    function automatic osc_sample_t step_oscillator();
        longint      car_fb;
        longint      mod_fb;
        longint      depth;
        longint      term;
        logic [63:0] total;
        osc_sample_t pair;
        car_fb = longint'($signed(car_fb_reg));
        mod_fb = longint'($signed(mod_fb_reg));
        depth  = longint'($signed(index_reg));
        // drop both feedback terms when both sit inside the dead zone
        if ((car_fb < 0 ? -car_fb : car_fb) <= FB_DEAD_ZONE &&
            (mod_fb < 0 ? -mod_fb : mod_fb) <= FB_DEAD_ZONE)
        begin
            car_fb = 0;
            mod_fb = 0;
        end
        car_phase = car_phase + car_inc_reg;
        mod_phase = mod_phase + mod_inc_reg;
        term      = mod_fb * longint'(last_mod);
        total     = ({32'd0, mod_phase} << PHASE_SHIFT) + term;
        last_mod  = sine_lookup(total);
        term      = car_fb * longint'(last_car) + depth * longint'(last_mod);
        total     = ({32'd0, car_phase} << PHASE_SHIFT) + term;
        last_car  = sine_lookup(total);
        pair.carrier   = last_car;
        pair.modulator = last_mod;
        return pair;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("testbench: mismatch at %0t: %s", $realtime, msg);
    endtask

    // Request driver: pop pending beats, hold each until taken, idle in bursts
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_requests.size() != 0 && $urandom_range(0, 99) < in_idle_pct)
            begin
                in_valid <= 1'b0;
                in_gap   <= $urandom_range(0, 11);
            end
            else if (pending_requests.size() != 0)
            begin
                in_valid       <= 1'b1;
                sample_request <= pending_requests.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (out_gap != 0)
        begin
            out_ready <= 1'b0;
            out_gap   <= out_gap - 1;
        end
        else if (rst_n && $urandom_range(0, 99) < out_idle_pct)
        begin
            out_ready <= 1'b0;
            out_gap   <= $urandom_range(0, 11);
        end
        else
            out_ready <= 1'b1;
    end

    // Check result beats against the oldest prediction, then predict taken requests
    always @(posedge clk)
    begin : result_check
        osc_sample_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("unexpected beat carrier=%0d modulator=%0d",
                                              carrier_sample, modulator_sample));
                else
                begin
                    want = expected_samples.pop_front();
                    if (carrier_sample !== want.carrier)
                        report_mismatch($sformatf("carrier_sample got %0d want %0d",
                                                  carrier_sample, want.carrier));
                    if (modulator_sample !== want.modulator)
                        report_mismatch($sformatf("modulator_sample got %0d want %0d",
                                                  modulator_sample, want.modulator));
                end
            end
            if (in_valid && in_ready && sample_request)
                expected_samples.push_back(step_oscillator());
        end
        in_taken <= rst_n && in_valid && in_ready;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CARRIER_INC:   car_inc_reg = value;
            REG_MODULATOR_INC: mod_inc_reg = value;
            REG_INDEX_OFS:     index_reg   = value;
            REG_CARRIER_FB:    car_fb_reg  = value;
            REG_MODULATOR_FB:  mod_fb_reg  = value;
            default:           ;
        endcase
    endtask

    task automatic apply_settings(input logic [31:0] car_inc, input logic [31:0] mod_inc,
                                  input logic [31:0] depth, input logic [31:0] car_fb,
                                  input logic [31:0] mod_fb);
        write_reg(REG_CARRIER_INC, car_inc);
        write_reg(REG_MODULATOR_INC, mod_inc);
        write_reg(REG_INDEX_OFS, depth);
        write_reg(REG_CARRIER_FB, car_fb);
        write_reg(REG_MODULATOR_FB, mod_fb);
    endtask

    // Queue count sample requests, mixed with empty beats, and set the idle rates
    task automatic queue_requests(input int count, input int noise_pct, input int in_pct,
                                  input int out_pct);
        int made;
        made = 0;
        @(posedge clk);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                pending_requests.push_back(1'b0);
            else
            begin
                pending_requests.push_back(1'b1);
                made++;
            end
        end
    endtask

    // Wait until every beat is sent and every result has come, then let the core settle
    task automatic wait_drained();
        while (pending_requests.size() != 0 || in_valid || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_increment();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0200_0000);
            2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] random_offset();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            // straddle the feedback dead zone edge
            1:       return 32'($urandom_range(0, 2 * FB_DEAD_ZONE + 2)) - 32'(FB_DEAD_ZONE + 1);
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:       return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return 32'd0;
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 5;
            2:       return 20;
            default: return 50;
        endcase
    endfunction

    initial
    begin
        int r;
        int sent;
        int count;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: zero steps, one radian of index, no feedback
        queue_requests(3, 0, 20, 20);
        pending_requests.push_back(1'b0);
        pending_requests.push_back(1'b1);
        wait_drained();

        // extreme steps and offsets, then writes to unused indexes
        apply_settings(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000);
        for (r = REG_MODULATOR_FB + 1; r < (1 << CFG_IDX_W); r++)
            write_reg(CFG_IDX_W'(r), $urandom);
        queue_requests(5, 0, 0, 0);
        wait_drained();

        // both feedback terms at the dead zone edge: ignored
        apply_settings(32'h0100_0000, 32'h0080_0000, 32'h7FFF_FFFF, 32'(FB_DEAD_ZONE),
                       -32'(FB_DEAD_ZONE));
        queue_requests(4, 0, 20, 0);
        wait_drained();

        // modulator feedback just past the edge: both terms active
        apply_settings(32'h0123_4567, 32'h0345_6789, ONE_RADIAN, -32'(FB_DEAD_ZONE),
                       32'(FB_DEAD_ZONE + 1));
        queue_requests(4, 0, 0, 20);
        wait_drained();

        // everything zero
        apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_requests(2, 0, 0, 0);
        pending_requests.push_back(1'b0);
        wait_drained();

        // random settings per phase, calm tail at the end
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            count = $urandom_range(40, 160);
            if (count > RANDOM_REQUESTS - sent)
                count = RANDOM_REQUESTS - sent;
            wait_drained();
            apply_settings(random_increment(), random_increment(), random_offset(),
                           random_offset(), random_offset());
            if (sent >= RANDOM_REQUESTS - CALM_TAIL)
                queue_requests(count, 8, 0, 0);
            else
                queue_requests(count, 8, pick_idle_pct(), pick_idle_pct());
            sent += count;
        end
        wait_drained();

        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/fmosc_pkg.sv
rtl/fm_two_operator_feedback_osc_core.sv
sim/testbench.sv
